// ----- hw/rtl/ssc_pkg.sv -----
`default_nettype none

package ssc_pkg;

  localparam int MAX_PATTERN  = 8;
  localparam int MAX_TEXT_LEN = 65536;

  localparam int WIN_DEPTH = 8;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int LEN_BOUND = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
  localparam int POS_LIMIT = (MAX_TEXT_LEN < 65536) ? MAX_TEXT_LEN : 65536;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int POS_W     = 17;
  localparam int IDX_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 64;

  localparam logic [IDX_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES = 8'd0,
    REG_PATTERN_LEN   = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             scan;
    logic [POS_W-1:0] pos;
  } scan_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ssc_cell.sv -----
`default_nettype none

module ssc_cell (
  input  wire logic                       clk,
  input  wire logic                       shift_en,
  input  wire logic [ssc_pkg::BYTE_W-1:0] byte_in,
  input  wire logic [ssc_pkg::BYTE_W-1:0] pattern_byte,
  output logic      [ssc_pkg::BYTE_W-1:0] byte_out,
  output logic                            hit
);

  logic [ssc_pkg::BYTE_W-1:0] data;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= byte_in;
    end
  end

  assign byte_out = data;
  assign hit      = (data == pattern_byte);

endmodule

`default_nettype wire

// ----- hw/rtl/ssc_tally.sv -----
`default_nettype none

module ssc_tally (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ssc_pkg::scan_t            s,
  input  wire logic                      hit,
  input  wire logic [ssc_pkg::LEN_W-1:0] eff_len,
  input  wire logic                      result_stall,
  output logic                           go,
  output logic                           result_valid,
  output logic                           found,
  output logic      [ssc_pkg::IDX_W-1:0] first_start,
  output logic      [ssc_pkg::IDX_W-1:0] last_start,
  output logic      [ssc_pkg::IDX_W-1:0] match_count,
  output logic                           overflow
);

  logic                        seen;
  logic [ssc_pkg::IDX_W-1:0]   first_pos;
  logic [ssc_pkg::IDX_W-1:0]   last_pos;
  logic [ssc_pkg::IDX_W-1:0]   count;
  logic [ssc_pkg::POS_W-1:0]   next_allowed;
  logic                        ovf;

  logic                        seen_next;
  logic [ssc_pkg::IDX_W-1:0]   first_pos_next;
  logic [ssc_pkg::IDX_W-1:0]   last_pos_next;
  logic [ssc_pkg::IDX_W-1:0]   count_next;
  logic [ssc_pkg::POS_W-1:0]   next_allowed_next;
  logic                        ovf_next;

  logic                        match;
  logic [ssc_pkg::POS_W-1:0]   start;

  assign go    = s.valid && (!s.last || !result_valid || !result_stall);
  assign match = s.scan && hit && (s.pos >= ssc_pkg::POS_W'(eff_len));
  assign start = s.pos - ssc_pkg::POS_W'(eff_len);

  always_comb begin
    seen_next         = seen || match;
    first_pos_next    = (match && !seen) ? start[ssc_pkg::IDX_W-1:0] : first_pos;
    last_pos_next     = match ? start[ssc_pkg::IDX_W-1:0] : last_pos;
    count_next        = count;
    next_allowed_next = next_allowed;
    ovf_next          = ovf || !s.scan;
    if (match && (start >= next_allowed)) begin
      count_next        = (count != ssc_pkg::CNT_MAX) ? count + 1'b1 : count;
      next_allowed_next = start + ssc_pkg::POS_W'(eff_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen         <= 1'b0;
      first_pos    <= '0;
      last_pos     <= '0;
      count        <= '0;
      next_allowed <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (go && s.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (go) begin
        if (s.last) begin
          seen         <= 1'b0;
          first_pos    <= '0;
          last_pos     <= '0;
          count        <= '0;
          next_allowed <= '0;
          ovf          <= 1'b0;
        end else begin
          seen         <= seen_next;
          first_pos    <= first_pos_next;
          last_pos     <= last_pos_next;
          count        <= count_next;
          next_allowed <= next_allowed_next;
          ovf          <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && s.last) begin
      found       <= seen_next;
      first_start <= seen_next ? first_pos_next : '0;
      last_start  <= seen_next ? last_pos_next : '0;
      match_count <= count_next;
      overflow    <= ovf_next;
    end
  end

`ifndef SYNTHESIS
  a_result_follows_end: assert property (@(posedge clk) disable iff (rst)
    go && s.last |=> result_valid)
    else $error("final request did not produce a result");

  a_count_implies_seen: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> seen)
    else $error("occurrences counted without any match");

  a_unseen_clear: assert property (@(posedge clk) disable iff (rst)
    !seen |-> (first_pos == '0) && (last_pos == '0) && (next_allowed == '0))
    else $error("match positions set without any match");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/substring_search_counter.sv -----
`default_nettype none

// Scans a text one byte per request against a pattern of 1 to 8 bytes.
// The text channel carries text_byte and text_end under text_valid and
// text_stall; a request is taken at an edge with valid high and stall low.
// The request that carries text_end closes the text and yields one result
// on the result channel: found, first_start, last_start, match_count and
// overflow, held under result_valid until result_stall is low.
// The pattern is loaded through the cfg port (index 0 the pattern bytes,
// first byte in bits 7 to 0; index 1 the length). The user must load it
// only while no text is in flight, which the block does not enforce.
// cfg_ready is always high. Throughput is one byte per cycle while
// text_stall is low: a row of eight window cells shifts on each taken
// byte and compares, and the match bookkeeping sits one stage behind;
// the final byte passes through it into the output registers, where
// result_valid rises. While a result waits under stall, non-final bytes
// keep flowing; the next final byte is held in the tally stage, with
// text_stall high, until the output register frees. Reset clears the text
// state and result valid, and sets the pattern to all zero, length one.

module substring_search_counter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           text_valid,
  output logic                                text_stall,
  input  wire logic [ssc_pkg::BYTE_W-1:0]     text_byte,
  input  wire logic                           text_end,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic                                found,
  output logic      [ssc_pkg::IDX_W-1:0]      first_start,
  output logic      [ssc_pkg::IDX_W-1:0]      last_start,
  output logic      [ssc_pkg::IDX_W-1:0]      match_count,
  output logic                                overflow,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssc_pkg::CFG_DAT_W-1:0]  cfg_data
);

  logic [ssc_pkg::WIN_DEPTH-1:0][ssc_pkg::BYTE_W-1:0] pattern_bytes;
  logic [ssc_pkg::LEN_W-1:0]                          pattern_len;
  logic [ssc_pkg::LEN_W-1:0]                          eff_len;

  logic [ssc_pkg::POS_W-1:0]                          pos;
  ssc_pkg::scan_t                                     s1;
  logic                                               accept;
  logic                                               scan_ok;
  logic                                               go;
  logic                                               shift_en;
  logic                                               window_hit;

  logic [ssc_pkg::WIN_DEPTH-1:0][ssc_pkg::BYTE_W-1:0] cell_byte;
  logic [ssc_pkg::WIN_DEPTH-1:0][ssc_pkg::BYTE_W-1:0] pat_sel;
  logic [ssc_pkg::WIN_DEPTH-1:0]                      cell_hit;
  logic [ssc_pkg::WIN_DEPTH-1:0]                      active;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes <= '0;
      pattern_len   <= ssc_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssc_pkg::REG_PATTERN_BYTES: pattern_bytes <= cfg_data;
        ssc_pkg::REG_PATTERN_LEN:   pattern_len   <= cfg_data[ssc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pattern_len == '0) begin
      eff_len = ssc_pkg::LEN_W'(1);
    end else if (pattern_len > ssc_pkg::LEN_W'(ssc_pkg::LEN_BOUND)) begin
      eff_len = ssc_pkg::LEN_W'(ssc_pkg::LEN_BOUND);
    end else begin
      eff_len = pattern_len;
    end
  end

  // Window entry j holds the byte j places back, which lines up with
  // pattern byte (length - 1 - j).
  always_comb begin
    logic [ssc_pkg::LEN_W-1:0] k;
    for (int j = 0; j < ssc_pkg::WIN_DEPTH; j++) begin
      k          = eff_len - ssc_pkg::LEN_W'(j) - ssc_pkg::LEN_W'(1);
      pat_sel[j] = pattern_bytes[k[ssc_pkg::WIN_IDX_W-1:0]];
      active[j]  = ssc_pkg::LEN_W'(j) < eff_len;
    end
  end

  assign window_hit = &(cell_hit | ~active);

  assign text_stall = s1.valid && !go;
  assign accept     = text_valid && !text_stall;
  assign scan_ok    = pos < ssc_pkg::POS_W'(ssc_pkg::POS_LIMIT);
  assign shift_en   = accept && scan_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      s1  <= '0;
    end else begin
      if (accept) begin
        s1.valid <= 1'b1;
        s1.last  <= text_end;
        s1.scan  <= scan_ok;
        s1.pos   <= pos + 1'b1;
        if (text_end) begin
          pos <= '0;
        end else if (scan_ok) begin
          pos <= pos + 1'b1;
        end
      end else if (go) begin
        s1.valid <= 1'b0;
      end
    end
  end

  for (genvar j = 0; j < ssc_pkg::WIN_DEPTH; j++) begin : g_cell
    logic [ssc_pkg::BYTE_W-1:0] feed;
    if (j == 0) begin : g_head
      assign feed = text_byte;
    end else begin : g_link
      assign feed = cell_byte[j-1];
    end
    ssc_cell u_cell (
      .clk          (clk),
      .shift_en     (shift_en),
      .byte_in      (feed),
      .pattern_byte (pat_sel[j]),
      .byte_out     (cell_byte[j]),
      .hit          (cell_hit[j])
    );
  end

  ssc_tally u_tally (
    .clk          (clk),
    .rst          (rst),
    .s            (s1),
    .hit          (window_hit),
    .eff_len      (eff_len),
    .result_stall (result_stall),
    .go           (go),
    .result_valid (result_valid),
    .found        (found),
    .first_start  (first_start),
    .last_start   (last_start),
    .match_count  (match_count),
    .overflow     (overflow)
  );

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= ssc_pkg::POS_W'(ssc_pkg::POS_LIMIT))
    else $error("text position ran past the limit");

  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    accept && text_end |=> (pos == '0))
    else $error("text position not cleared after the final byte");

  a_stall_needs_work: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> s1.valid && s1.last && result_valid)
    else $error("text channel stalled with nothing blocking it");
`endif

endmodule

`default_nettype wire
